// ----- hdl/sclx_pkg.sv -----
// ----------------------------------------------------------------------------
// sclx_pkg
// shared types and defaults for the shell command lexer
// ----------------------------------------------------------------------------
`default_nettype none

package sclx_pkg;

    // default token and word limits, and depth of the front-to-back queue
    localparam int TOKEN_LIMIT_DEF = 99;
    localparam int WORD_CHARS_DEF  = 49;
    localparam int QUEUE_DEPTH_DEF = 4;

    typedef enum logic [2:0] {
        KIND_CHAR   = 3'd0,
        KIND_WEND   = 3'd1,
        KIND_PIPE   = 3'd2,
        KIND_IN     = 3'd3,
        KIND_OUT    = 3'd4,
        KIND_APPEND = 3'd5,
        KIND_END    = 3'd6,
        KIND_BAD    = 3'd7
    } kind_t;

    // packed so that tok_kind sits in the lowest bits
    typedef struct packed {
        logic [6:0] tok_num;
        logic [5:0] char_pos;
        logic [7:0] char_byte;
        kind_t      tok_kind;
    } result_t;

    // one queue entry: the one or two results of a request
    typedef struct packed {
        logic    two;
        result_t r0;
        result_t r1;
    } entry_t;

endpackage

`default_nettype wire

// ----- hdl/sclx_fifo.sv -----
// ----------------------------------------------------------------------------
// sclx_fifo
// small register queue between the lexer front and back
// ----------------------------------------------------------------------------
`default_nettype none

module sclx_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  in_ready,
    input  wire logic             pop,
    output logic                  out_valid,
    output logic [WIDTH-1:0]      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push & in_ready;
    assign do_pop    = pop & out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sclx_front.sv -----
// ----------------------------------------------------------------------------
// sclx_front
// byte classifier and lexer state; turns each request into a queue entry
// ----------------------------------------------------------------------------
`default_nettype none

module sclx_front #(
    parameter int TOKEN_LIMIT = sclx_pkg::TOKEN_LIMIT_DEF,
    parameter int WORD_CHARS  = sclx_pkg::WORD_CHARS_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    input  wire logic            in_ready,
    input  wire logic [7:0]      char_value,
    input  wire logic            end_of_line,
    output logic                 push,
    output sclx_pkg::entry_t     push_entry
);

    localparam logic [7:0] CH_PIPE  = 8'h7C;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [6:0] TOK_LIM  = 7'(TOKEN_LIMIT);
    localparam logic [5:0] WORD_LIM = 6'(WORD_CHARS);

    typedef enum logic [2:0] {
        MODE_IDLE = 3'b001,
        MODE_WORD = 3'b010,
        MODE_GT   = 3'b100
    } mode_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER || c == CH_DASH ||
               c == CH_DOT;
    endfunction

    function automatic sclx_pkg::result_t make_tok(input sclx_pkg::kind_t k,
                                                   input logic [6:0] num);
        sclx_pkg::result_t r;
        r.tok_num   = num;
        r.char_pos  = '0;
        r.char_byte = '0;
        r.tok_kind  = k;
        return r;
    endfunction

    function automatic sclx_pkg::result_t make_chr(input sclx_pkg::kind_t k,
                                                   input logic [7:0] c,
                                                   input logic [5:0] pos,
                                                   input logic [6:0] num);
        sclx_pkg::result_t r;
        r.tok_num   = num;
        r.char_pos  = pos;
        r.char_byte = c;
        r.tok_kind  = k;
        return r;
    endfunction

    mode_t      mode_reg, mode_next;
    logic [6:0] count_reg, count_next;
    logic [5:0] wlen_reg, wlen_next;
    logic       wdrop_reg, wdrop_next;

    logic              accept, blank, stop, consumed;
    logic              a_tok, a_chr, a_valid, a_emit;
    logic              b_tok, b_chr, b_bad, b_valid, b_emit;
    sclx_pkg::kind_t   a_kind, b_kind;
    sclx_pkg::result_t a_res, b_res;
    logic [6:0]        cnt_mid;

    assign accept = in_valid & in_ready;
    assign blank  = is_blank(char_value);
    assign stop   = blank || char_value == CH_PIPE || char_value == CH_LT ||
                    char_value == CH_GT;

    always_comb begin
        mode_next  = mode_reg;
        wlen_next  = wlen_reg;
        wdrop_next = wdrop_reg;
        consumed   = 1'b0;
        a_tok      = 1'b0;
        a_chr      = 1'b0;
        a_kind     = sclx_pkg::KIND_OUT;
        b_tok      = 1'b0;
        b_chr      = 1'b0;
        b_bad      = 1'b0;
        b_kind     = sclx_pkg::KIND_END;

        // first slot: flush of a pending '>' or word, or a word char
        if (end_of_line) begin
            a_tok  = (mode_reg == MODE_WORD) || (mode_reg == MODE_GT);
            a_kind = (mode_reg == MODE_WORD) ? sclx_pkg::KIND_WEND : sclx_pkg::KIND_OUT;
            b_tok  = 1'b1;
        end else begin
            unique case (mode_reg)
                MODE_GT: begin
                    a_tok     = 1'b1;
                    consumed  = (char_value == CH_GT);
                    a_kind    = consumed ? sclx_pkg::KIND_APPEND : sclx_pkg::KIND_OUT;
                    mode_next = MODE_IDLE;
                end
                MODE_WORD: begin
                    if (stop) begin
                        a_tok      = 1'b1;
                        a_kind     = sclx_pkg::KIND_WEND;
                        mode_next  = MODE_IDLE;
                        wlen_next  = '0;
                        wdrop_next = 1'b0;
                    end else begin
                        consumed = 1'b1;
                        if (wlen_reg < WORD_LIM) begin
                            a_chr     = !wdrop_reg;
                            wlen_next = wlen_reg + 1'b1;
                        end
                    end
                end
                MODE_IDLE: begin
                end
                default: begin
                end
            endcase
        end

        a_emit  = a_tok && (count_reg < TOK_LIM);
        a_valid = a_emit || a_chr;
        cnt_mid = count_reg + {6'd0, a_emit};

        // second slot: the byte itself at a token start
        if (!end_of_line && !consumed) begin
            priority if (blank) begin
            end else if (char_value == CH_PIPE) begin
                b_tok  = 1'b1;
                b_kind = sclx_pkg::KIND_PIPE;
            end else if (char_value == CH_LT) begin
                b_tok  = 1'b1;
                b_kind = sclx_pkg::KIND_IN;
            end else if (char_value == CH_GT) begin
                mode_next = MODE_GT;
            end else if (is_word_start(char_value)) begin
                mode_next  = MODE_WORD;
                wdrop_next = (cnt_mid >= TOK_LIM);
                wlen_next  = 6'd1;
                b_chr      = (cnt_mid < TOK_LIM);
            end else begin
                b_bad = 1'b1;
            end
        end

        b_emit  = b_tok && (cnt_mid < TOK_LIM);
        b_valid = b_emit || b_chr || b_bad;

        if (a_chr) begin
            a_res = make_chr(sclx_pkg::KIND_CHAR, char_value, wlen_reg, count_reg);
        end else begin
            a_res = make_tok(a_kind, count_reg);
        end

        priority if (b_chr) begin
            b_res = make_chr(sclx_pkg::KIND_CHAR, char_value, '0, cnt_mid);
        end else if (b_bad) begin
            b_res = make_chr(sclx_pkg::KIND_BAD, char_value, '0, '0);
        end else begin
            b_res = make_tok(b_kind, cnt_mid);
        end

        count_next = cnt_mid + {6'd0, b_emit};

        // end of line returns the whole line state to reset
        if (end_of_line) begin
            mode_next  = MODE_IDLE;
            count_next = '0;
            wlen_next  = '0;
            wdrop_next = 1'b0;
        end
    end

    assign push          = accept & (a_valid | b_valid);
    assign push_entry.two = a_valid & b_valid;
    assign push_entry.r0  = a_valid ? a_res : b_res;
    assign push_entry.r1  = b_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            wlen_reg  <= '0;
            wdrop_reg <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            wlen_reg  <= wlen_next;
            wdrop_reg <= wdrop_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/sclx_back.sv -----
// ----------------------------------------------------------------------------
// sclx_back
// drains queue entries one result per cycle into the output register while the output is not stalled
// ----------------------------------------------------------------------------
`default_nettype none

module sclx_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             q_valid,
    input  wire sclx_pkg::entry_t q_entry,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output sclx_pkg::result_t     m_res,
    output logic                  m_tlast
);

    logic              m_valid_reg, m_valid_next;
    sclx_pkg::result_t m_res_reg;
    logic              m_last_reg;
    logic              sel_reg, sel_next;
    logic              load, final_res;

    // load the output register when it is empty or being taken
    assign load      = q_valid & (!m_valid_reg | m_tready);
    assign final_res = !q_entry.two | sel_reg;
    assign q_pop     = load & final_res;

    always_comb begin
        sel_next     = sel_reg;
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
            sel_next     = !final_res;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sel_reg     <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            sel_reg     <= sel_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_res_reg  <= sel_reg ? q_entry.r1 : q_entry.r0;
            m_last_reg <= final_res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_res    = m_res_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- hdl/shell_command_lexer.sv -----
// ----------------------------------------------------------------------------
// shell_command_lexer
// byte-serial shell command line tokenizer with decoupled front and back
// ----------------------------------------------------------------------------
//
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata[7:0] char_value, s_tlast end_of_line
// m_*       out  m_tvalid/m_tready  m_tdata token fields, m_tlast last of request
//
// - the front takes one request per cycle while the queue has room; each
//   request yields zero, one or two results, which enter the queue as one entry
// - the back sends one result per cycle while m_tready is high, so a run of
//   two-result requests drains slower than the front takes them; the queue
//   depth sets how long the front keeps going while the back or the output stalls
// - the first result is registered twice on its way out: into the queue, then
//   into the output register
// - synchronous active-low reset clears the lexer state, the queue and the
//   output valid flag; no clearing pass
//
`default_nettype none

module shell_command_lexer #(
    parameter int TOKEN_LIMIT = sclx_pkg::TOKEN_LIMIT_DEF,
    parameter int WORD_CHARS  = sclx_pkg::WORD_CHARS_DEF,
    parameter int QUEUE_DEPTH = sclx_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input request channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_value
    input  wire logic        s_tlast,   // end_of_line
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [2:0] token_kind, [10:3] char_byte,
                                        // [16:11] char_position, [23:17] token_number
    output logic             m_tlast    // last result of its request
);

    // front to queue
    logic              push;
    sclx_pkg::entry_t  push_entry;
    logic              q_ready;

    // queue to back
    logic              q_valid;
    logic              q_pop;
    sclx_pkg::entry_t  q_entry;

    sclx_pkg::result_t m_res;

    // the front may take a request whenever the queue has room
    assign s_tready = q_ready;

    sclx_front #(
        .TOKEN_LIMIT (TOKEN_LIMIT),
        .WORD_CHARS  (WORD_CHARS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (q_ready),
        .char_value  (s_tdata),
        .end_of_line (s_tlast),
        .push        (push),
        .push_entry  (push_entry)
    );

    // queue entries carry both results of a request
    sclx_fifo #(
        .WIDTH ($bits(sclx_pkg::entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_entry),
        .in_ready  (q_ready),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_entry)
    );

    sclx_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res),
        .m_tlast  (m_tlast)
    );

    // result struct is already laid out low field first
    assign m_tdata = m_res;

endmodule

`default_nettype wire

// ----- dv/shell_command_lexer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_command_lexer_checker
// watches both channels of the lexer, predicts every token result of each
// accepted request and compares the results in order, field by field
// ----------------------------------------------------------------------------

module shell_command_lexer_checker #(
    parameter int TOKEN_LIMIT = sclx_pkg::TOKEN_LIMIT_DEF,
    parameter int WORD_CHARS  = sclx_pkg::WORD_CHARS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tlast,
    output int          outstanding,
    output int          error_count
);

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PIPE  = "|";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_DOT   = ".";

    typedef enum logic [1:0] {
        SCAN_IDLE = 2'd0,
        SCAN_WORD = 2'd1,
        SCAN_GT   = 2'd2
    } scan_mode_t;

    typedef struct packed {
        logic              closes;   // last result of its request
        sclx_pkg::result_t tok;
    } token_exp_t;

    scan_mode_t  scan_mode;
    logic [6:0]  tokens_seen;
    logic [5:0]  word_len;
    logic        word_muted;
    int          errors = 0;

    token_exp_t  expected_tokens[$];
    token_exp_t  step_tokens[$];

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic starts_word(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
               (c >= "a" && c <= "z") || c == CH_UNDER || c == CH_DASH || c == CH_DOT;
    endfunction

    function automatic logic breaks_word(input logic [7:0] c);
        return is_blank(c) || c == CH_PIPE || c == CH_LT || c == CH_GT;
    endfunction

    task automatic clear_line();
        scan_mode   = SCAN_IDLE;
        tokens_seen = '0;
        word_len    = '0;
        word_muted  = 1'b0;
    endtask

    task automatic put_token(input sclx_pkg::kind_t k, input logic [7:0] b,
                             input logic [5:0] p, input logic [6:0] n);
        token_exp_t e;
        e.closes        = 1'b0;
        e.tok.tok_kind  = k;
        e.tok.char_byte = b;
        e.tok.char_pos  = p;
        e.tok.tok_num   = n;
        step_tokens.push_back(e);
    endtask

    // tokens past the limit vanish without a trace
    task automatic count_token(input sclx_pkg::kind_t k);
        if (tokens_seen < TOKEN_LIMIT) begin
            put_token(k, 8'h00, 6'd0, tokens_seen);
            tokens_seen++;
        end
    endtask

    task automatic keep_char(input logic [7:0] c);
        if (word_len < WORD_CHARS) begin
            if (!word_muted)
                put_token(sclx_pkg::KIND_CHAR, c, word_len, tokens_seen);
            word_len++;
        end
    endtask

    task automatic lex_request(input logic [7:0] c, input logic eol);
        logic       handled;
        token_exp_t e;
        handled = 1'b0;
        step_tokens.delete();
        if (eol) begin
            if (scan_mode == SCAN_WORD)
                count_token(sclx_pkg::KIND_WEND);
            else if (scan_mode == SCAN_GT)
                count_token(sclx_pkg::KIND_OUT);
            count_token(sclx_pkg::KIND_END);
            clear_line();
        end else begin
            if (scan_mode == SCAN_GT) begin
                scan_mode = SCAN_IDLE;
                if (c == CH_GT) begin
                    count_token(sclx_pkg::KIND_APPEND);
                    handled = 1'b1;
                end else begin
                    count_token(sclx_pkg::KIND_OUT);
                end
            end else if (scan_mode == SCAN_WORD) begin
                if (breaks_word(c)) begin
                    count_token(sclx_pkg::KIND_WEND);
                    scan_mode  = SCAN_IDLE;
                    word_len   = '0;
                    word_muted = 1'b0;
                end else begin
                    keep_char(c);
                    handled = 1'b1;
                end
            end
            // blanks fall through without effect
            if (!handled && !is_blank(c)) begin
                if (c == CH_PIPE) begin
                    count_token(sclx_pkg::KIND_PIPE);
                end else if (c == CH_LT) begin
                    count_token(sclx_pkg::KIND_IN);
                end else if (c == CH_GT) begin
                    scan_mode = SCAN_GT;
                end else if (starts_word(c)) begin
                    scan_mode  = SCAN_WORD;
                    word_len   = '0;
                    word_muted = (tokens_seen >= TOKEN_LIMIT);
                    keep_char(c);
                end else begin
                    put_token(sclx_pkg::KIND_BAD, c, 6'd0, 7'd0);
                end
            end
        end
        foreach (step_tokens[i]) begin
            e        = step_tokens[i];
            e.closes = (i == step_tokens.size() - 1);
            expected_tokens.push_back(e);
        end
    endtask

    task automatic check_result();
        sclx_pkg::result_t got;
        token_exp_t        want;
        got = sclx_pkg::result_t'(m_tdata);
        if (expected_tokens.size() == 0) begin
            if (errors < 10)
                $display("unexpected result: kind %0d byte %02h pos %0d num %0d last %0b",
                         got.tok_kind, got.char_byte, got.char_pos, got.tok_num, m_tlast);
            errors++;
        end else begin
            want = expected_tokens.pop_front();
            if (got.tok_kind !== want.tok.tok_kind || got.char_byte !== want.tok.char_byte ||
                got.char_pos !== want.tok.char_pos || got.tok_num !== want.tok.tok_num ||
                m_tlast !== want.closes) begin
                if (errors < 10)
                    $display("result mismatch: exp kind %0d byte %02h pos %0d num %0d last %0b",
                             want.tok.tok_kind, want.tok.char_byte, want.tok.char_pos,
                             want.tok.tok_num, want.closes,
                             " / got kind %0d byte %02h pos %0d num %0d last %0b",
                             got.tok_kind, got.char_byte, got.char_pos, got.tok_num, m_tlast);
                errors++;
            end
        end
    endtask

    // results are taken before requests so that a result can never match an
    // expectation created at the same edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_line();
            expected_tokens.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready)
                lex_request(s_tdata, s_tlast);
        end
        outstanding <= expected_tokens.size();
        error_count <= errors;
    end

endmodule

// ----- dv/shell_command_lexer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shell_command_lexer_test
// drives command lines into the lexer with random gaps and output stalls;
// a checker beside the block predicts and compares every token result
// ----------------------------------------------------------------------------

module shell_command_lexer_test;

    // about 1100 requests in total, directed part included
    localparam int ITEM_TARGET = 1100;
    // far beyond the slowest legal run: every request with two results, each
    // result held back by the longest stall, every request by the longest gap
    localparam int RUN_LIMIT_NS = 6_000_000;

    // command line bytes used by the stimulus
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PIPE  = "|";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_UNDER = "_";
    localparam logic [7:0] CH_DASH  = "-";
    localparam logic [7:0] CH_DOT   = ".";

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;   // [7:0] char_value
    logic        s_tlast  = 1'b0;    // end_of_line
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;            // [2:0] token_kind, [10:3] char_byte,
                                     // [16:11] char_position, [23:17] token_number
    logic        m_tlast;            // last result of its request

    int          outstanding;
    int          error_count;
    int          sent_count = 0;
    bit          tx_calm    = 1'b0;  // sender runs without gaps
    bit          rx_calm    = 1'b0;  // receiver runs without stalls

    shell_command_lexer i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    shell_command_lexer_checker i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .outstanding (outstanding),
        .error_count (error_count)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // one request: optional gap, then hold valid until the handshake
    // valid stays high after the handshake so back-to-back requests never
    // lower and raise it in the same step
    task automatic push_byte(input logic [7:0] c, input logic eol);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    // alphanumeric, underscore, dash or dot
    function automatic logic [7:0] word_start_char();
        int k;
        k = $urandom_range(0, 64);
        if (k < 10)
            return 8'("0" + k);
        else if (k < 36)
            return 8'("A" + k - 10);
        else if (k < 62)
            return 8'("a" + k - 36);
        else if (k == 62)
            return CH_UNDER;
        else if (k == 63)
            return CH_DASH;
        else
            return CH_DOT;
    endfunction

    // space, tab, newline, vertical tab, form feed or carriage return
    function automatic logic [7:0] blank_char();
        int k;
        k = $urandom_range(0, 5);
        return (k == 0) ? CH_SPACE : 8'(CH_TAB + k - 1);
    endfunction

    // bytes that cannot start a token but sit fine inside a word:
    // zero, high bytes and punctuation from '!' to ','
    function automatic logic [7:0] junk_char();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            3:       return 8'($urandom_range(8'h21, 8'h2C));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    task automatic send_word(input int len);
        push_byte(word_start_char(), 1'b0);
        for (int i = 1; i < len; i++) begin
            if ($urandom_range(0, 99) < 85)
                push_byte(word_start_char(), 1'b0);
            else
                push_byte(junk_char(), 1'b0);
        end
    endtask

    // one well-formed command line with random content; dense lines pack
    // short tokens back to back so that the token limit is crossed
    task automatic send_line(input int n_tok, input bit dense, input int long_pct);
        int sel;
        int len;
        for (int t = 0; t < n_tok; t++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45) begin
                if (dense)
                    len = $urandom_range(1, 3);
                else if ($urandom_range(0, 99) < long_pct)
                    len = $urandom_range(45, 60);   // may spill past the kept length
                else
                    len = $urandom_range(1, 8);
                send_word(len);
            end else if (sel < 55) begin
                push_byte(CH_PIPE, 1'b0);
            end else if (sel < 62) begin
                push_byte(CH_LT, 1'b0);
            end else if (sel < 70) begin
                push_byte(CH_GT, 1'b0);
            end else if (sel < 77) begin
                push_byte(CH_GT, 1'b0);
                push_byte(CH_GT, 1'b0);
            end else if (sel < 85) begin
                push_byte(junk_char(), 1'b0);
            end else begin
                push_byte(8'($urandom_range(0, 255)), 1'b0);   // plain noise
            end
            // separators: sometimes none, so tokens butt against each other
            if (!dense || $urandom_range(0, 9) == 0)
                repeat ($urandom_range(0, 2)) push_byte(blank_char(), 1'b0);
        end
        // end of line carries a random byte that must be ignored
        push_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // receiver: a fresh stall before every result, with calm stretches
    initial begin
        int gap;
        int taken;
        taken = 0;
        repeat (11) @(posedge aclk);
        forever begin
            if (taken % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
            gap = rx_calm ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
        end
    end

    // stimulus and verdict
    initial begin
        int line_no;
        line_no = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed line: every token kind, every blank, zero and high bytes
        // both inside a word and at a token start
        push_byte(CH_TAB, 1'b0);     // blank before anything
        push_byte("a", 1'b0);        // word opens
        push_byte(8'hFF, 1'b0);      // high byte kept inside a word
        push_byte("0", 1'b0);
        push_byte(CH_PIPE, 1'b0);    // word end, then pipe
        push_byte(CH_LT, 1'b0);      // input redirect
        push_byte(CH_VT, 1'b0);
        push_byte("Z", 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(CH_GT, 1'b0);      // word end, redirect held back
        push_byte(CH_GT, 1'b0);      // second one makes an append
        push_byte(CH_UNDER, 1'b0);
        push_byte(CH_GT, 1'b0);
        push_byte(CH_DASH, 1'b0);    // output redirect, then a word
        push_byte(8'h00, 1'b0);      // zero byte kept inside a word
        push_byte(CH_SPACE, 1'b0);
        push_byte(8'h00, 1'b0);      // zero byte at a token start is invalid
        push_byte(8'hFF, 1'b0);      // so is a high byte
        push_byte(CH_CR, 1'b0);
        push_byte(CH_LF, 1'b0);
        push_byte(CH_FF, 1'b0);
        push_byte(CH_DOT, 1'b0);
        push_byte(CH_GT, 1'b0);
        push_byte(8'hFF, 1'b1);      // end of line flushes the pending redirect
        push_byte("z", 1'b0);
        push_byte(8'h00, 1'b1);      // end of line closes the open word
        hold_until_drained();

        // random command lines, one of them dense enough to hit the limit
        while (sent_count < ITEM_TARGET) begin
            tx_calm = ($urandom_range(0, 4) == 0);
            if (line_no % 12 == 5)
                send_line($urandom_range(260, 300), 1'b1, 0);
            else
                send_line($urandom_range(0, 25), 1'b0, 10);
            if (line_no == 3)
                hold_until_drained();
            line_no++;
        end

        // drain, then stay idle to catch stray results
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
